### rtl/mpmp_pkg.sv
// ----------------------------------------------------------------------------
// mpmp_pkg
// Shared types, constants and helpers for the 3x3 matrix power mod prime block.
// ----------------------------------------------------------------------------
package mpmp_pkg;

	localparam int unsigned EXP_BITS = 63;
	localparam int unsigned ENT_W    = 30;

	localparam logic [ENT_W-1:0] MODP = 30'd998244353;

	// Barrett constant floor(2^60 / p), fits in 31 bits
	localparam logic [63:0] BARRETT_FULL = (64'd1 << 60) / 64'd998244353;
	localparam logic [30:0] BARRETT_M    = BARRETT_FULL[30:0];

	localparam logic [1:0] IDX_LAST  = 2'd2;
	localparam logic [4:0] LOAD_LAST = 5'd17;
	localparam logic [4:0] LOAD_HALF = 5'd9;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CHECK,
		ST_MUL,
		ST_MUL_WAIT,
		ST_SQR,
		ST_SQR_WAIT,
		ST_OUT,
		ST_FIN,
		ST_DONE
	} mpmp_state_t;

	typedef struct packed {
		logic       capture;
		logic       load;
		logic       ident;
		logic [3:0] idx;
		logic [1:0] wr_bank;
		logic       issue;
		logic       rd_out;
		logic [1:0] xbank;
		logic [1:0] ybank;
		logic [1:0] row;
		logic [1:0] col;
		logic [1:0] kk;
		logic       shift;
	} mpmp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic exp_zero;
		logic exp_lsb;
	} mpmp_stat_t;

	typedef struct packed {
		logic [1:0] row;
		logic [1:0] col;
		logic [1:0] kk;
	} mpmp_tag_t;

	// entry offset row*3+col within a bank
	function automatic logic [3:0] ent_ofs(input logic [1:0] row, input logic [1:0] col);
		ent_ofs = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
	endfunction

	// bank*9 + offset
	function automatic logic [4:0] mat_addr(input logic [1:0] bank, input logic [3:0] ofs);
		mat_addr = {bank, 3'b000} + {3'b000, bank} + {1'b0, ofs};
	endfunction

endpackage

### rtl/matrix_power_mod_prime_top.sv
// ----------------------------------------------------------------------------
// matrix_power_mod_prime_top
// 3x3 matrix power modulo 998244353 by square-and-multiply.
// ----------------------------------------------------------------------------
// Usage: drive base_00..base_22 (residues; values >= p are reduced) and
// exponent, and pulse start. The word is taken at the clock edge where start
// is high and busy is low; busy then stays high until the result is out.
// The result appears on power_00..power_22, marked by a done pulse that is
// high for a single cycle; the receiver must take it then, it cannot hold it off.
// Each 3x3 product is formed as 27 entry products issued one per cycle into
// one shared pipelined modular multiplier. A new word can be accepted from
// the cycle after done. Reset clears the sequencer and pipeline valids; the
// matrix memory needs no clearing since every item loads it before use.
// ----------------------------------------------------------------------------
module matrix_power_mod_prime_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [29:0] base_00,
	input  logic [29:0] base_01,
	input  logic [29:0] base_02,
	input  logic [29:0] base_10,
	input  logic [29:0] base_11,
	input  logic [29:0] base_12,
	input  logic [29:0] base_20,
	input  logic [29:0] base_21,
	input  logic [29:0] base_22,
	input  logic [62:0] exponent,
	output logic        done,
	output logic [29:0] power_00,
	output logic [29:0] power_01,
	output logic [29:0] power_02,
	output logic [29:0] power_10,
	output logic [29:0] power_11,
	output logic [29:0] power_12,
	output logic [29:0] power_20,
	output logic [29:0] power_21,
	output logic [29:0] power_22
);

	mpmp_pkg::mpmp_cmd_t  cmd;
	mpmp_pkg::mpmp_stat_t stat;
	logic [29:0] base_arr [9];
	logic [29:0] power_arr [9];

	assign base_arr[0] = base_00;
	assign base_arr[1] = base_01;
	assign base_arr[2] = base_02;
	assign base_arr[3] = base_10;
	assign base_arr[4] = base_11;
	assign base_arr[5] = base_12;
	assign base_arr[6] = base_20;
	assign base_arr[7] = base_21;
	assign base_arr[8] = base_22;

	assign power_00 = power_arr[0];
	assign power_01 = power_arr[1];
	assign power_02 = power_arr[2];
	assign power_10 = power_arr[3];
	assign power_11 = power_arr[4];
	assign power_12 = power_arr[5];
	assign power_20 = power_arr[6];
	assign power_21 = power_arr[7];
	assign power_22 = power_arr[8];

	mpmp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mpmp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.base     (base_arr),
		.exponent (exponent),
		.stat     (stat),
		.power    (power_arr)
	);

endmodule

### rtl/mpmp_ctrl.sv
// ----------------------------------------------------------------------------
// mpmp_ctrl
// Sequencer: load, square-and-multiply loop over exponent bits, read-out.
// ----------------------------------------------------------------------------
module mpmp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mpmp_pkg::mpmp_stat_t stat,
	output mpmp_pkg::mpmp_cmd_t  cmd,
	output logic                 busy,
	output logic                 done
);

	mpmp_pkg::mpmp_state_t state_q, state_nx;
	logic [4:0] cnt_q;
	logic [1:0] row_q, col_q, kk_q;
	logic [1:0] a_bank_q, s_bank_q, f_bank_q;
	logic       last_prod, last_out;

	assign last_prod = (row_q == mpmp_pkg::IDX_LAST) && (col_q == mpmp_pkg::IDX_LAST)
		&& (kk_q == mpmp_pkg::IDX_LAST);
	assign last_out  = (row_q == mpmp_pkg::IDX_LAST) && (kk_q == mpmp_pkg::IDX_LAST);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			mpmp_pkg::ST_IDLE: begin
				if (start) state_nx = mpmp_pkg::ST_LOAD;
			end
			mpmp_pkg::ST_LOAD: begin
				if (cnt_q == mpmp_pkg::LOAD_LAST) state_nx = mpmp_pkg::ST_CHECK;
			end
			mpmp_pkg::ST_CHECK: begin
				if (stat.exp_zero)     state_nx = mpmp_pkg::ST_OUT;
				else if (stat.exp_lsb) state_nx = mpmp_pkg::ST_MUL;
				else                   state_nx = mpmp_pkg::ST_SQR;
			end
			mpmp_pkg::ST_MUL: begin
				if (last_prod) state_nx = mpmp_pkg::ST_MUL_WAIT;
			end
			mpmp_pkg::ST_MUL_WAIT: begin
				if (!stat.pipe_busy) state_nx = mpmp_pkg::ST_SQR;
			end
			mpmp_pkg::ST_SQR: begin
				if (last_prod) state_nx = mpmp_pkg::ST_SQR_WAIT;
			end
			mpmp_pkg::ST_SQR_WAIT: begin
				if (!stat.pipe_busy) state_nx = mpmp_pkg::ST_CHECK;
			end
			mpmp_pkg::ST_OUT: begin
				if (last_out) state_nx = mpmp_pkg::ST_FIN;
			end
			mpmp_pkg::ST_FIN:  state_nx = mpmp_pkg::ST_DONE;
			mpmp_pkg::ST_DONE: state_nx = mpmp_pkg::ST_IDLE;
			default:           state_nx = mpmp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == mpmp_pkg::ST_IDLE) && start;
		cmd.load    = (state_q == mpmp_pkg::ST_LOAD);
		cmd.ident   = (cnt_q >= mpmp_pkg::LOAD_HALF);
		cmd.idx     = cmd.ident ? 4'(cnt_q - mpmp_pkg::LOAD_HALF) : cnt_q[3:0];
		if (cmd.load) cmd.wr_bank = cmd.ident ? a_bank_q : s_bank_q;
		else          cmd.wr_bank = f_bank_q;
		cmd.issue   = (state_q == mpmp_pkg::ST_MUL) || (state_q == mpmp_pkg::ST_SQR)
			|| (state_q == mpmp_pkg::ST_OUT);
		cmd.rd_out  = (state_q == mpmp_pkg::ST_OUT);
		cmd.xbank   = (state_q == mpmp_pkg::ST_SQR) ? s_bank_q : a_bank_q;
		cmd.ybank   = s_bank_q;
		cmd.row     = row_q;
		cmd.col     = col_q;
		cmd.kk      = kk_q;
		cmd.shift   = (state_q == mpmp_pkg::ST_SQR_WAIT) && !stat.pipe_busy;
		busy        = (state_q != mpmp_pkg::ST_IDLE);
		done        = (state_q == mpmp_pkg::ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mpmp_pkg::ST_IDLE;
			cnt_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			kk_q     <= '0;
			a_bank_q <= 2'd0;
			s_bank_q <= 2'd1;
			f_bank_q <= 2'd2;
		end else begin
			state_q <= state_nx;
			if (state_q == mpmp_pkg::ST_LOAD) cnt_q <= cnt_q + 5'd1;
			else                              cnt_q <= '0;

			// k fastest, then column, then row; all wrap to zero at the end
			if ((state_q == mpmp_pkg::ST_MUL) || (state_q == mpmp_pkg::ST_SQR)) begin
				if (kk_q == mpmp_pkg::IDX_LAST) begin
					kk_q <= '0;
					if (col_q == mpmp_pkg::IDX_LAST) begin
						col_q <= '0;
						row_q <= (row_q == mpmp_pkg::IDX_LAST) ? 2'd0 : row_q + 2'd1;
					end else begin
						col_q <= col_q + 2'd1;
					end
				end else begin
					kk_q <= kk_q + 2'd1;
				end
			end else if (state_q == mpmp_pkg::ST_OUT) begin
				// read-out walks row and kk, kk standing for the column
				if (kk_q == mpmp_pkg::IDX_LAST) begin
					kk_q  <= '0;
					row_q <= (row_q == mpmp_pkg::IDX_LAST) ? 2'd0 : row_q + 2'd1;
				end else begin
					kk_q <= kk_q + 2'd1;
				end
			end

			// results land in the free bank, which then takes the place of the target
			if ((state_q == mpmp_pkg::ST_MUL_WAIT) && !stat.pipe_busy) begin
				a_bank_q <= f_bank_q;
				f_bank_q <= a_bank_q;
			end else if ((state_q == mpmp_pkg::ST_SQR_WAIT) && !stat.pipe_busy) begin
				s_bank_q <= f_bank_q;
				f_bank_q <= s_bank_q;
			end
		end
	end

endmodule

### rtl/mpmp_dp.sv
// ----------------------------------------------------------------------------
// mpmp_dp
// Datapath: three-bank matrix memory, pipelined modular multiply-accumulate
// (Barrett reduction), exponent shifter and result registers.
// ----------------------------------------------------------------------------
module mpmp_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpmp_pkg::mpmp_cmd_t  cmd,
	input  logic [29:0]          base [9],
	input  logic [62:0]          exponent,
	output mpmp_pkg::mpmp_stat_t stat,
	output logic [29:0]          power [9]
);

	logic [29:0] base_q [9];
	logic [62:0] exp_q;
	logic [29:0] mat_mem [27];
	logic [29:0] power_q [9];

	logic [29:0] x_s1, y_s1;
	logic        v_s1, out_s1, v_s2, v_s3, v_s4, v_s5;
	mpmp_pkg::mpmp_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [59:0] prod_s2;
	logic [61:0] q2_s3;
	logic [31:0] lo_s3, lo_s4, qp_s4;
	logic [30:0] r_s5;
	logic [29:0] sum_q;

	logic [4:0]  x_addr, y_addr, wr_addr;
	logic [29:0] ld_data, ld_raw, red, sum_nx;
	logic [30:0] add_raw;
	logic [60:0] qp_full;
	logic [31:0] diff;
	logic        acc_wr;

	assign x_addr = mpmp_pkg::mat_addr(cmd.xbank, mpmp_pkg::ent_ofs(cmd.row, cmd.kk));
	assign y_addr = mpmp_pkg::mat_addr(cmd.ybank, mpmp_pkg::ent_ofs(cmd.kk, cmd.col));

	always_comb begin
		ld_raw = base_q[cmd.idx];
		if (cmd.ident) begin
			ld_data = ((cmd.idx == 4'd0) || (cmd.idx == 4'd4) || (cmd.idx == 4'd8)) ?
				30'd1 : 30'd0;
		end else begin
			ld_data = (ld_raw >= mpmp_pkg::MODP) ? ld_raw - mpmp_pkg::MODP : ld_raw;
		end
	end

	// final correction of the Barrett remainder, then running sum mod p
	always_comb begin
		red     = (r_s5 >= {1'b0, mpmp_pkg::MODP}) ? 30'(r_s5 - {1'b0, mpmp_pkg::MODP})
			: r_s5[29:0];
		add_raw = {1'b0, sum_q} + {1'b0, red};
		if (tag_s5.kk == 2'd0) sum_nx = red;
		else sum_nx = (add_raw >= {1'b0, mpmp_pkg::MODP}) ?
			30'(add_raw - {1'b0, mpmp_pkg::MODP}) : add_raw[29:0];
		acc_wr  = v_s5 && (tag_s5.kk == mpmp_pkg::IDX_LAST);
		wr_addr = cmd.load ? mpmp_pkg::mat_addr(cmd.wr_bank, cmd.idx)
			: mpmp_pkg::mat_addr(cmd.wr_bank, mpmp_pkg::ent_ofs(tag_s5.row, tag_s5.col));
		qp_full = {30'd0, q2_s3[61:31]} * {31'd0, mpmp_pkg::MODP};
		diff    = lo_s4 - qp_s4;
	end

	// matrix memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.load) mat_mem[wr_addr] <= ld_data;
		else if (acc_wr) mat_mem[wr_addr] <= sum_nx;
		x_s1 <= mat_mem[x_addr];
		y_s1 <= mat_mem[y_addr];
	end

	// payload and arithmetic pipeline
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			base_q <= base;
			exp_q  <= exponent;
		end else if (cmd.shift) begin
			exp_q <= {1'b0, exp_q[62:1]};
		end
		tag_s1  <= '{row: cmd.row, col: cmd.col, kk: cmd.kk};
		tag_s2  <= tag_s1;
		tag_s3  <= tag_s2;
		tag_s4  <= tag_s3;
		tag_s5  <= tag_s4;
		prod_s2 <= {30'd0, x_s1} * {30'd0, y_s1};
		q2_s3   <= {31'd0, prod_s2[59:29]} * {31'd0, mpmp_pkg::BARRETT_M};
		lo_s3   <= prod_s2[31:0];
		lo_s4   <= lo_s3;
		qp_s4   <= qp_full[31:0];
		// remainder is below 3p; first correction here
		r_s5    <= (diff >= {2'b00, mpmp_pkg::MODP}) ? 31'(diff - {2'b00, mpmp_pkg::MODP})
			: diff[30:0];
		if (v_s5) sum_q <= sum_nx;
		if (v_s1 && out_s1) power_q[mpmp_pkg::ent_ofs(tag_s1.row, tag_s1.kk)] <= x_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			out_s1 <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			out_s1 <= cmd.rd_out;
			v_s2   <= v_s1 && !out_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
		end
	end

	assign stat.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign stat.exp_zero  = (exp_q == 63'd0);
	assign stat.exp_lsb   = exp_q[0];
	assign power          = power_q;

endmodule
